FILE: rtl/bblru_pkg.sv
`default_nettype none
package bblru_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int KEY_W    = 24;
  localparam int SIZE_W   = 34;
  localparam int BUDGET_W = 40;
  localparam int USED_W   = 41;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int EVC_OUT_W  = 7;
  localparam int EVC_SAT    = 127;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS_LOADED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS_NO_SRC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS_FAILED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INS_FAILED  = 3'd6;

  // per-cell control from the sequencer
  typedef struct packed {
    logic occupied;
    logic take_left;
    logic take_front;
  } cell_ctrl_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_DECIDE = 6'b000100,
    S_EVICT  = 6'b001000,
    S_PLACE  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/byte_budget_lru_cache_policy.sv
`default_nettype none
// Size-aware LRU tag store: a row of cells, one per recency position, each
// holding slot, key and size; cell 0 is most recent. A request is accepted,
// every cell is compared against the key, and the result is acted on. A
// miss with a source, or an insert, then evicts entries from the tail until
// no further eviction is due and places a new entry, but a failed load does
// not place one; the result register is loaded last. One request is in
// work at a time.
module byte_budget_lru_cache_policy
  import bblru_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [BUDGET_W-1:0]      cache_budget,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     req_type,
  input  wire [7:0]               layer,
  input  wire [15:0]              expert_num,
  input  wire [SIZE_W-1:0]        entry_bytes,
  input  wire                     source_present,
  input  wire                     load_ok,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [STATUS_W-1:0]     status,
  output logic [SLOT_OUT_W-1:0]   slot,
  output logic [EVC_OUT_W-1:0]    evicted_count,
  output logic [USED_W-1:0]       bytes_used,
  output logic [CNT_W-1:0]        hit_total,
  output logic [CNT_W-1:0]        miss_total,
  output logic [CNT_W-1:0]        eviction_total
);

  localparam int SW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  state_t state;
  logic [BUDGET_W-1:0] budget;
  logic               r_ins, r_src, r_ok;
  logic [KEY_W-1:0]   r_key;
  logic [SIZE_W-1:0]  r_need;
  logic [CW-1:0]      count;
  logic [USED_W-1:0]  used;
  logic [CNT_W-1:0]   hits, misses, evicts;
  logic [CW-1:0]      evc;
  logic               found;
  logic [SW-1:0]      found_pos;
  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]      res_slot;

  logic [KEY_W-1:0]   c_key  [NUM_ENTRIES];
  logic [SIZE_W-1:0]  c_size [NUM_ENTRIES];
  logic [SW-1:0]      c_slot [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] c_match;
  cell_ctrl_t         c_ctrl [NUM_ENTRIES];

  logic               move;
  logic [SW-1:0]      move_pos;
  logic [KEY_W-1:0]   front_key;
  logic [SIZE_W-1:0]  front_size;
  logic [SW-1:0]      front_slot;
  logic [SW-1:0]      tail_pos;
  logic [SW-1:0]      free_pos;
  logic               over;
  logic               drop;
  logic               enc_hit;
  logic [SW-1:0]      enc_pos;
  logic [31:0]        evc_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign tail_pos  = SW'(count - CW'(1));
  assign free_pos  = SW'(count);
  assign over = ({1'b0, used} + {8'b0, r_need}) > {2'b0, budget};
  assign drop = (state == S_EVICT) && (count != '0) &&
                (over || (r_ok && count == CW'(NUM_ENTRIES)));
  assign evc_ext = 32'(evc);

  // row of cells
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    always_comb begin
      c_ctrl[i].occupied   = (CW'(i) < count);
      c_ctrl[i].take_front = move && (i == 0);
      c_ctrl[i].take_left  = move && (i != 0) && (SW'(i) <= move_pos);
    end
    bblru_cell #(.SW(SW), .IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (c_ctrl[i]),
      .search_key (r_key),
      .left_key   (c_key[L]),
      .left_size  (c_size[L]),
      .left_slot  (c_slot[L]),
      .front_key  (front_key),
      .front_size (front_size),
      .front_slot (front_slot),
      .key        (c_key[i]),
      .size       (c_size[i]),
      .slot       (c_slot[i]),
      .match      (c_match[i])
    );
  end

  always_comb begin
    enc_hit = |c_match;
    enc_pos = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (c_match[i]) enc_pos = SW'(i);
    end
  end

  // move to front: a hit lifts its own entry, a placement lifts the first free slot
  always_comb begin
    move       = 1'b0;
    move_pos   = found_pos;
    front_key  = c_key[found_pos];
    front_size = c_size[found_pos];
    front_slot = c_slot[found_pos];
    if (state == S_DECIDE && !r_ins && found) begin
      move = 1'b1;
    end else if (state == S_PLACE) begin
      move       = 1'b1;
      move_pos   = free_pos;
      front_key  = r_key;
      front_size = r_need;
      front_slot = c_slot[free_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (cfg_valid && cfg_ready) begin
      budget <= cache_budget;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      r_ins  <= req_type;
      r_key  <= {layer, expert_num};
      r_need <= entry_bytes;
      r_src  <= source_present;
      r_ok   <= load_ok;
    end
    if (state == S_SEARCH) begin
      found     <= enc_hit;
      found_pos <= enc_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      used   <= '0;
      hits   <= '0;
      misses <= '0;
      evicts <= '0;
      evc    <= '0;
      res_status <= ST_HIT;
      res_slot   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) out_valid <= 1'b0;
      if (drop) begin
        count  <= count - CW'(1);
        used   <= used - {7'b0, c_size[tail_pos]};
        evicts <= evicts + 1'b1;
        evc    <= evc + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            evc   <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: state <= S_DECIDE;
        S_DECIDE: begin
          if (found) begin
            res_slot <= c_slot[found_pos];
            if (!r_ins) begin
              hits       <= hits + 1'b1;
              res_status <= ST_HIT;
            end else begin
              res_status <= ST_PRESENT;
            end
            state <= S_RESP;
          end else if (!r_ins) begin
            res_slot <= '0;
            misses   <= misses + 1'b1;
            if (!r_src) begin
              res_status <= ST_MISS_NO_SRC;
              state      <= S_RESP;
            end else begin
              state <= S_EVICT;
            end
          end else begin
            res_slot <= '0;
            state    <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (!drop) begin
            if (!r_ok) begin
              res_status <= r_ins ? ST_INS_FAILED : ST_MISS_FAILED;
              state      <= S_RESP;
            end else begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          count      <= count + CW'(1);
          used       <= used + {7'b0, r_need};
          res_slot   <= c_slot[free_pos];
          res_status <= r_ins ? ST_INSERTED : ST_MISS_LOADED;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            slot           <= SLOT_OUT_W'(32'(res_slot));
            evicted_count  <= (evc_ext > 32'(EVC_SAT)) ? EVC_OUT_W'(EVC_SAT)
                                                       : evc_ext[EVC_OUT_W-1:0];
            bytes_used     <= used;
            hit_total      <= hits;
            miss_total     <= misses;
            eviction_total <= evicts;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bblru_cell.sv
`default_nettype none
module bblru_cell #(
  parameter int SW = 6,
  parameter int IDX = 0
) (
  input  wire                           clk,
  input  wire                           rst,
  input  bblru_pkg::cell_ctrl_t         ctrl,
  input  wire [bblru_pkg::KEY_W-1:0]    search_key,
  input  wire [bblru_pkg::KEY_W-1:0]    left_key,
  input  wire [bblru_pkg::SIZE_W-1:0]   left_size,
  input  wire [SW-1:0]                  left_slot,
  input  wire [bblru_pkg::KEY_W-1:0]    front_key,
  input  wire [bblru_pkg::SIZE_W-1:0]   front_size,
  input  wire [SW-1:0]                  front_slot,
  output logic [bblru_pkg::KEY_W-1:0]   key,
  output logic [bblru_pkg::SIZE_W-1:0]  size,
  output logic [SW-1:0]                 slot,
  output logic                          match
);
  import bblru_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SW'(IDX);
    end else if (ctrl.take_front) begin
      slot <= front_slot;
    end else if (ctrl.take_left) begin
      slot <= left_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_front) begin
      key  <= front_key;
      size <= front_size;
    end else if (ctrl.take_left) begin
      key  <= left_key;
      size <= left_size;
    end
  end

  assign match = ctrl.occupied && (key == search_key);

endmodule
`default_nettype wire
